// ----- hw/rtl/osc_message_parser_core_macros.svh -----
// Assertion macros for the checker file.
`ifndef OSC_MESSAGE_PARSER_CORE_MACROS_SVH
`define OSC_MESSAGE_PARSER_CORE_MACROS_SVH

// Property checked on the rising edge, ignored while reset is held
`define OMP_ASSERT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error("omp assertion failed");

// Property checked on every rising edge, reset included
`define OMP_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("omp assertion failed");

`endif

// ----- hw/rtl/omp_pkg.sv -----
package omp_pkg;

  // Default size of the type-tag store
  localparam int DEF_MAX_TAGS = 16;

  // Depth of the result queue (power of two)
  localparam int OUT_DEPTH = 4;

  // Characters that steer the parse
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [3:0] {
    PH_ADDR_START,
    PH_ADDR,
    PH_ADDR_PAD,
    PH_TAG_START,
    PH_TAGS,
    PH_TAG_PAD,
    PH_ARGS,
    PH_WORD,
    PH_STR,
    PH_STR_PAD,
    PH_IDLE,
    PH_DISCARD
  } phase_t;

  typedef enum logic [2:0] {
    KIND_ADDR_CHAR,
    KIND_ADDR_END,
    KIND_FLOAT,
    KIND_INT,
    KIND_STR_CHAR,
    KIND_STR_END,
    KIND_DONE
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_REJECT,
    ST_CUT,
    ST_OVERFLOW
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    status_t     status;
    logic        run_end;
  } result_t;

  // Results produced by one accepted byte: r0 first, then r1
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_res_t;

endpackage

// ----- hw/rtl/omp_if.sv -----
// Byte input channel
interface omp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result output channel
interface omp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic [1:0]  status;
  logic        run_end;

  modport source (output valid, output kind, output value, output status,
                  output run_end, input ready);
  modport sink   (input valid, input kind, input value, input status,
                  input run_end, output ready);
endinterface

// ----- hw/rtl/omp_ram.sv -----
module omp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- hw/rtl/omp_parse.sv -----
module omp_parse #(
  parameter int MAX_TAGS = omp_pkg::DEF_MAX_TAGS,
  localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1,
  localparam int CW = $clog2(MAX_TAGS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [7:0]          tag_rdata,
  output omp_pkg::step_res_t  res,
  output logic                tag_we,
  output logic [AW-1:0]       tag_waddr,
  output logic [7:0]          tag_wdata,
  output logic [AW-1:0]       tag_raddr
);

  localparam logic [CW-1:0] TAG_LIMIT = CW'(MAX_TAGS);

  omp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]      bcnt_r, bcnt_nxt;
  logic [1:0]      wpos_r, wpos_nxt;
  logic [CW-1:0]   ttot_r, ttot_nxt;
  logic [CW-1:0]   arg_r, arg_nxt;
  logic [23:0]     wcol_r, wcol_nxt;
  logic            rej_r, rej_nxt;
  logic            sopen_r, sopen_nxt;
  logic            ovf_r, ovf_nxt;

  logic             emit;
  omp_pkg::kind_t   p_kind;
  logic [31:0]      p_value;
  omp_pkg::status_t done_status;
  omp_pkg::result_t p_res, d_res;

  // Parse step for the byte on the input
  always_comb begin
    phase_nxt   = phase_r;
    ttot_nxt    = ttot_r;
    arg_nxt     = arg_r;
    wcol_nxt    = wcol_r;
    rej_nxt     = rej_r;
    sopen_nxt   = sopen_r;
    ovf_nxt     = ovf_r;
    emit        = 1'b0;
    p_kind      = omp_pkg::KIND_ADDR_CHAR;
    p_value     = 32'd0;
    tag_we      = 1'b0;
    tag_waddr   = ttot_r[AW-1:0];
    tag_wdata   = data_byte;
    done_status = omp_pkg::ST_OK;
    wpos_nxt    = wpos_r + 2'd1;
    bcnt_nxt    = (bcnt_r < 3'd4) ? bcnt_r + 3'd1 : bcnt_r;

    case (phase_r)
      omp_pkg::PH_ADDR_START: begin
        if (data_byte == omp_pkg::CH_SLASH) begin
          emit      = 1'b1;
          p_value   = {24'd0, data_byte};
          phase_nxt = omp_pkg::PH_ADDR;
        end else begin
          rej_nxt   = 1'b1;
          phase_nxt = omp_pkg::PH_DISCARD;
        end
      end
      omp_pkg::PH_ADDR: begin
        emit = 1'b1;
        if (data_byte != omp_pkg::CH_NUL) begin
          p_value = {24'd0, data_byte};
        end else begin
          p_kind    = omp_pkg::KIND_ADDR_END;
          phase_nxt = (wpos_nxt == 2'd0) ? omp_pkg::PH_TAG_START : omp_pkg::PH_ADDR_PAD;
        end
      end
      omp_pkg::PH_ADDR_PAD: begin
        if (wpos_nxt == 2'd0) phase_nxt = omp_pkg::PH_TAG_START;
      end
      omp_pkg::PH_TAG_START: begin
        phase_nxt = (data_byte == omp_pkg::CH_COMMA) ? omp_pkg::PH_TAGS : omp_pkg::PH_IDLE;
      end
      omp_pkg::PH_TAGS: begin
        if (data_byte == omp_pkg::CH_NUL) begin
          phase_nxt = (wpos_nxt == 2'd0) ? omp_pkg::PH_ARGS : omp_pkg::PH_TAG_PAD;
        end else if (ttot_r < TAG_LIMIT) begin
          tag_we   = 1'b1;
          ttot_nxt = ttot_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      omp_pkg::PH_TAG_PAD, omp_pkg::PH_STR_PAD: begin
        if (wpos_nxt == 2'd0) phase_nxt = omp_pkg::PH_ARGS;
      end
      omp_pkg::PH_ARGS: begin
        if (arg_r >= ttot_r || arg_r >= TAG_LIMIT) begin
          phase_nxt = omp_pkg::PH_IDLE;
        end else if (tag_rdata == omp_pkg::CH_F || tag_rdata == omp_pkg::CH_I) begin
          wcol_nxt  = {16'd0, data_byte};
          phase_nxt = omp_pkg::PH_WORD;
        end else if (tag_rdata == omp_pkg::CH_S) begin
          // string opens on this byte, and may close on it too
          emit = 1'b1;
          if (data_byte != omp_pkg::CH_NUL) begin
            p_kind    = omp_pkg::KIND_STR_CHAR;
            p_value   = {24'd0, data_byte};
            sopen_nxt = 1'b1;
            phase_nxt = omp_pkg::PH_STR;
          end else begin
            p_kind    = omp_pkg::KIND_STR_END;
            arg_nxt   = arg_r + 1'b1;
            phase_nxt = (wpos_nxt == 2'd0) ? omp_pkg::PH_ARGS : omp_pkg::PH_STR_PAD;
          end
        end else begin
          phase_nxt = omp_pkg::PH_IDLE;
        end
      end
      omp_pkg::PH_WORD: begin
        if (wpos_r == 2'd3) begin
          emit      = 1'b1;
          p_kind    = (tag_rdata == omp_pkg::CH_F) ? omp_pkg::KIND_FLOAT : omp_pkg::KIND_INT;
          p_value   = {wcol_r, data_byte};
          wcol_nxt  = 24'd0;
          arg_nxt   = arg_r + 1'b1;
          phase_nxt = omp_pkg::PH_ARGS;
        end else begin
          wcol_nxt = {wcol_r[15:0], data_byte};
        end
      end
      omp_pkg::PH_STR: begin
        emit = 1'b1;
        if (data_byte != omp_pkg::CH_NUL) begin
          p_kind  = omp_pkg::KIND_STR_CHAR;
          p_value = {24'd0, data_byte};
        end else begin
          p_kind    = omp_pkg::KIND_STR_END;
          sopen_nxt = 1'b0;
          arg_nxt   = arg_r + 1'b1;
          phase_nxt = (wpos_nxt == 2'd0) ? omp_pkg::PH_ARGS : omp_pkg::PH_STR_PAD;
        end
      end
      omp_pkg::PH_IDLE, omp_pkg::PH_DISCARD: begin
      end
      default: begin
        phase_nxt = omp_pkg::PH_IDLE;
      end
    endcase

    // Packet end: status in priority order, then back to the start state
    if (last_byte) begin
      if (rej_nxt || bcnt_nxt < 3'd4 || phase_nxt == omp_pkg::PH_ADDR_START ||
          phase_nxt == omp_pkg::PH_ADDR) begin
        done_status = omp_pkg::ST_REJECT;
      end else if (sopen_nxt) begin
        done_status = omp_pkg::ST_CUT;
      end else if (ovf_nxt) begin
        done_status = omp_pkg::ST_OVERFLOW;
      end
      phase_nxt = omp_pkg::PH_ADDR_START;
      bcnt_nxt  = 3'd0;
      wpos_nxt  = 2'd0;
      ttot_nxt  = '0;
      arg_nxt   = '0;
      wcol_nxt  = 24'd0;
      rej_nxt   = 1'b0;
      sopen_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  // Result packing; run_end goes on the last result of the byte
  always_comb begin
    p_res.kind    = p_kind;
    p_res.value   = p_value;
    p_res.status  = omp_pkg::ST_OK;
    p_res.run_end = !last_byte;
    d_res.kind    = omp_pkg::KIND_DONE;
    d_res.value   = 32'd0;
    d_res.status  = done_status;
    d_res.run_end = 1'b1;
    res.r1        = d_res;
    res.r0        = emit ? p_res : d_res;
    if (!accept) begin
      res.count = 2'd0;
    end else begin
      res.count = {1'b0, emit} + {1'b0, last_byte};
    end
  end

  // Tag read address follows the argument index after this edge
  assign tag_raddr = accept ? arg_nxt[AW-1:0] : arg_r[AW-1:0];

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= omp_pkg::PH_ADDR_START;
      bcnt_r  <= 3'd0;
      wpos_r  <= 2'd0;
      ttot_r  <= '0;
      arg_r   <= '0;
      wcol_r  <= 24'd0;
      rej_r   <= 1'b0;
      sopen_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      wpos_r  <= wpos_nxt;
      ttot_r  <= ttot_nxt;
      arg_r   <= arg_nxt;
      wcol_r  <= wcol_nxt;
      rej_r   <= rej_nxt;
      sopen_r <= sopen_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ----- hw/rtl/omp_out_fifo.sv -----
module omp_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  omp_pkg::step_res_t push,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output omp_pkg::result_t   out_res
);

  localparam int DEPTH = omp_pkg::OUT_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam logic [NW-1:0] ROOM_LIMIT = NW'(DEPTH - 2);

  omp_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wptr_p1;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rptr_r];
  // room for the two results a byte may bring
  assign space_ok  = (cnt_r <= ROOM_LIMIT);
  // pointers wrap on the power-of-two depth
  assign wptr_p1   = wptr_r + 1'b1;

  // Pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r + PW'(push.count);
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + NW'(push.count) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Result storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wptr_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem_r[wptr_p1] <= push.r1;
    end
  end

endmodule

// ----- hw/rtl/osc_message_parser_core.sv -----
// Each result is registered in the result queue before it shows on out_chan.
// Throughput: one byte per cycle while the result queue has room; a byte that
// gives two results (the final byte with a parse result) needs two result
// transfers; the four-entry queue sets how far input can run ahead of output.
// Reset: rst_n synchronous, active low; clears parse state and the result queue.
module osc_message_parser_core #(
  parameter int MAX_TAGS = omp_pkg::DEF_MAX_TAGS
) (
  input  logic      clk,
  input  logic      rst_n,
  omp_in_if.sink    in_chan,
  omp_out_if.source out_chan
);

  localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;

  logic               accept;
  logic               space_ok;
  omp_pkg::step_res_t step_res;
  omp_pkg::result_t   out_res;
  logic               tag_we;
  logic [AW-1:0]      tag_waddr;
  logic [7:0]         tag_wdata;
  logic [AW-1:0]      tag_raddr;
  logic [7:0]         tag_rdata;

  // Input transaction
  assign in_chan.ready = space_ok;
  assign accept        = in_chan.valid && space_ok;

  omp_parse #(
    .MAX_TAGS (MAX_TAGS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_chan.data_byte),
    .last_byte (in_chan.last_byte),
    .tag_rdata (tag_rdata),
    .res       (step_res),
    .tag_we    (tag_we),
    .tag_waddr (tag_waddr),
    .tag_wdata (tag_wdata),
    .tag_raddr (tag_raddr)
  );

  // Type-tag store
  omp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_TAGS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  omp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step_res),
    .space_ok  (space_ok),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  // Result transaction payload
  assign out_chan.kind    = out_res.kind;
  assign out_chan.value   = out_res.value;
  assign out_chan.status  = out_res.status;
  assign out_chan.run_end = out_res.run_end;

endmodule

// ----- hw/rtl/omp_checker.sv -----
`include "osc_message_parser_core_macros.svh"

module omp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [31:0] value,
  input logic [1:0]  status,
  input logic        run_end
);

  // A stalled result transaction holds its kind, value and status
  `OMP_ASSERT(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value) && $stable(status))

  // Status only rides on packet done
  `OMP_ASSERT(a_status_done, clk, rst_n,
    out_valid && kind != omp_pkg::KIND_DONE |-> status == omp_pkg::ST_OK)

  // Packet done always closes the run of its byte
  `OMP_ASSERT(a_done_run_end, clk, rst_n,
    out_valid && kind == omp_pkg::KIND_DONE |-> run_end && value == 32'd0)

  // Reset empties the result queue and input is open right after
  `OMP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && in_ready)

endmodule

bind osc_message_parser_core omp_checker u_omp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .kind      (out_chan.kind),
  .value     (out_chan.value),
  .status    (out_chan.status),
  .run_end   (out_chan.run_end)
);

// ----- tb/osc_message_parser_core_test.sv -----
module osc_message_parser_core_test;
  import omp_pkg::*;

  localparam int TAG_SLOTS    = DEF_MAX_TAGS;
  localparam int TARGET_BYTES = 1650;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 100;

  // Byte-level OSC parse prediction and in-order result checking
  class osc_result_scoreboard;
    phase_t      phase;
    logic [2:0]  seen;
    logic [1:0]  wpos;
    logic [7:0]  tags [TAG_SLOTS];
    logic [4:0]  ntags;
    logic [4:0]  argi;
    logic [23:0] word_acc;
    bit          rejected;
    bit          str_open;
    bit          overflowed;
    result_t     step_results[$];
    result_t     pending_results[$];
    int          errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase      = PH_ADDR_START;
      seen       = '0;
      wpos       = '0;
      ntags      = '0;
      argi       = '0;
      word_acc   = '0;
      rejected   = 0;
      str_open   = 0;
      overflowed = 0;
      foreach (tags[i]) tags[i] = '0;
    endfunction

    function void emit(kind_t k, logic [31:0] v, status_t s);
      result_t r;
      r.kind    = k;
      r.value   = v;
      r.status  = s;
      r.run_end = 1'b0;
      step_results = {step_results, r};
    endfunction

    // One character of a string argument; NUL closes it
    function void string_char(logic [7:0] b);
      if (b != CH_NUL) begin
        emit(KIND_STR_CHAR, {24'd0, b}, ST_OK);
      end else begin
        emit(KIND_STR_END, 32'd0, ST_OK);
        str_open = 0;
        argi++;
        phase = (wpos == 2'd0) ? PH_ARGS : PH_STR_PAD;
      end
    endfunction

    // Work out the results of one accepted input transaction
    function void note_byte(logic [7:0] b, logic last);
      logic [1:0] pos;
      logic [7:0] t;
      status_t    st;
      step_results.delete();
      pos  = wpos;
      wpos = pos + 2'd1;
      if (seen < 3'd4) seen++;

      case (phase)
        PH_ADDR_START: begin
          if (b == CH_SLASH) begin
            emit(KIND_ADDR_CHAR, {24'd0, b}, ST_OK);
            phase = PH_ADDR;
          end else begin
            rejected = 1;
            phase    = PH_DISCARD;
          end
        end
        PH_ADDR: begin
          if (b != CH_NUL) begin
            emit(KIND_ADDR_CHAR, {24'd0, b}, ST_OK);
          end else begin
            emit(KIND_ADDR_END, 32'd0, ST_OK);
            phase = (wpos == 2'd0) ? PH_TAG_START : PH_ADDR_PAD;
          end
        end
        PH_ADDR_PAD: begin
          if (wpos == 2'd0) phase = PH_TAG_START;
        end
        PH_TAG_START: begin
          phase = (b == CH_COMMA) ? PH_TAGS : PH_IDLE;
        end
        PH_TAGS: begin
          if (b == CH_NUL) begin
            phase = (wpos == 2'd0) ? PH_ARGS : PH_TAG_PAD;
          end else if (ntags < TAG_SLOTS) begin
            tags[ntags] = b;
            ntags++;
          end else begin
            overflowed = 1;
          end
        end
        PH_TAG_PAD, PH_STR_PAD: begin
          if (wpos == 2'd0) phase = PH_ARGS;
        end
        PH_ARGS: begin
          if (argi >= ntags) begin
            phase = PH_IDLE;
          end else begin
            t = tags[argi];
            if (t == CH_F || t == CH_I) begin
              word_acc = {16'd0, b};
              phase    = PH_WORD;
            end else if (t == CH_S) begin
              str_open = 1;
              phase    = PH_STR;
              string_char(b);
            end else begin
              phase = PH_IDLE;
            end
          end
        end
        PH_WORD: begin
          if (pos == 2'd3) begin
            emit((tags[argi] == CH_F) ? KIND_FLOAT : KIND_INT, {word_acc, b}, ST_OK);
            word_acc = '0;
            argi++;
            phase = PH_ARGS;
          end else begin
            word_acc = {word_acc[15:0], b};
          end
        end
        PH_STR: string_char(b);
        default: ;
      endcase

      // Packet end: status by priority, then back to the reset state
      if (last) begin
        st = ST_OK;
        if (rejected || seen < 3'd4 || phase == PH_ADDR_START || phase == PH_ADDR)
          st = ST_REJECT;
        else if (str_open)
          st = ST_CUT;
        else if (overflowed)
          st = ST_OVERFLOW;
        emit(KIND_DONE, 32'd0, st);
        clear_state();
      end

      if (step_results.size() > 0) step_results[step_results.size() - 1].run_end = 1'b1;
      pending_results = {pending_results, step_results};
    endfunction

    task report_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
      if (errors < PRINT_CAP)
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got_v, exp_v);
      errors++;
    endtask

    // Compare one accepted result transaction with the oldest expectation
    task check_result(logic [2:0] kind, logic [31:0] value, logic [1:0] status,
                      logic run_end);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", {29'd0, kind}, 32'd0);
        return;
      end
      exp_r = pending_results.pop_front();
      if (kind !== exp_r.kind) report_mismatch("kind", {29'd0, kind}, {29'd0, exp_r.kind});
      if (value !== exp_r.value) report_mismatch("value", value, exp_r.value);
      if (status !== exp_r.status)
        report_mismatch("status", {30'd0, status}, {30'd0, exp_r.status});
      if (run_end !== exp_r.run_end)
        report_mismatch("run_end", {31'd0, run_end}, {31'd0, exp_r.run_end});
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   quiet_in;
  bit   quiet_out;
  int   stall_left;
  int   sent_count;
  logic [7:0] pkt_bytes[$];
  osc_result_scoreboard sb;

  omp_in_if  in_chan();
  omp_out_if out_chan();

  osc_message_parser_core #(.MAX_TAGS(TAG_SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Stretches with no idling on either side
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) quiet_in <= !quiet_in;
    if ($urandom_range(0, 299) == 0) quiet_out <= !quiet_out;
  end

  // Result-side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap(quiet_out);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.kind, out_chan.value, out_chan.status, out_chan.run_end);
  end

  // Watchdog: cycles without any transaction on either channel
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle = 0;
      else
        idle++;
    end
    $display("osc_message_parser_core_test: FAIL");
    $finish;
  end

  // Offer one byte, optionally after a gap, and hold it until taken
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last_byte <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_byte(b, last);
    sent_count++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  // Append one byte to the packet under construction
  task automatic add_byte(logic [7:0] b);
    pkt_bytes = {pkt_bytes, b};
  endtask

  task automatic add_random(int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  // Padding up to the next 4-byte boundary, any content
  task automatic pad_word();
    while (pkt_bytes.size() % 4 != 0) add_random(1);
  endtask

  // Mostly well-formed packets with random content; some noise, some cut short
  task automatic build_packet();
    int sel;
    int n;
    int r;
    logic [7:0] tag;
    logic [7:0] tag_list[$];
    pkt_bytes.delete();
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      add_random($urandom_range(1, 12));
      return;
    end
    add_byte(CH_SLASH);
    repeat ($urandom_range(0, 7)) add_byte(8'($urandom_range(1, 255)));
    add_byte(CH_NUL);
    pad_word();
    if (sel == 1) return;
    if (sel == 2) add_random(1);
    else add_byte(CH_COMMA);

    // Type tags; occasionally more than the store holds
    n = ($urandom_range(0, 14) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r < 7) tag = CH_F;
      else if (r < 13) tag = CH_I;
      else if (r < 19) tag = CH_S;
      else tag = 8'($urandom_range(1, 255));
      tag_list = {tag_list, tag};
      add_byte(tag);
    end
    add_byte(CH_NUL);
    pad_word();

    // Arguments, stopping at an unknown tag
    for (int i = 0; i < tag_list.size() && i < TAG_SLOTS; i++) begin
      if (tag_list[i] == CH_F || tag_list[i] == CH_I) begin
        add_random(4);
      end else if (tag_list[i] == CH_S) begin
        repeat ($urandom_range(0, 7)) add_byte(8'($urandom_range(1, 255)));
        add_byte(CH_NUL);
        pad_word();
      end else begin
        break;
      end
    end
    if ($urandom_range(0, 4) == 0) add_random($urandom_range(1, 6));
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, pkt_bytes.size());
      pkt_bytes = pkt_bytes[0:n-1];
    end
  endtask

  // Stimulus
  initial begin
    sb = new();
    sent_count = 0;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= 8'h00;
    in_chan.last_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short packet, bad first byte, address only, missing comma, int word
    pkt_bytes = '{CH_SLASH};
    send_packet();
    pkt_bytes = '{8'h41, 8'h62, 8'h00, 8'h00};
    send_packet();
    pkt_bytes = '{CH_SLASH, 8'hFF, CH_NUL, 8'h00};
    send_packet();
    pkt_bytes = '{CH_SLASH, CH_NUL, 8'h00, 8'h00, 8'h78};
    send_packet();
    pkt_bytes = '{CH_SLASH, CH_NUL, 8'h00, 8'h00, CH_COMMA, CH_I, CH_NUL, 8'h00,
                  8'h80, 8'h00, 8'h00, 8'hFF};
    send_packet();

    // Random packets
    while (sent_count < TARGET_BYTES) begin
      build_packet();
      send_packet();
    end
    in_chan.valid <= 1'b0;

    // Drain
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("osc_message_parser_core_test: PASS");
    else
      $display("osc_message_parser_core_test: FAIL");
    $finish;
  end

endmodule
